### sv/xcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcv_pkg: shared types and constants of the XOR checksum line validator
// Item structs, byte classes, parser phases, error codes and the hex decoder.
// ----------------------------------------------------------------------------
package xcv_pkg;

  // Fixed field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 11;
  localparam int ERR_W  = 3;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

  // Reset value of the payload buffer size register
  localparam logic [LEN_W-1:0] BUF_SIZE_RESET = 11'd128;

  // Queue between classifier and parser
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              end_of_line;
  } in_item_t;

  typedef struct packed {
    logic              line_ok;
    logic [ERR_W-1:0]  error_kind;
    logic [BYTE_W-1:0] computed_checksum;
    logic [BYTE_W-1:0] received_checksum;
    logic [LEN_W-1:0]  payload_length;
  } out_item_t;

  // Classified byte as it travels through the queue
  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              last;
    logic              is_dollar;
    logic              is_star;
    logic              is_eol;
    logic              hex_ok;
    logic [3:0]        hex_digit;
  } cls_t;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_HEX_HI  = 3'd2,
    PH_HEX_LO  = 3'd3,
    PH_TAIL    = 3'd4,
    PH_DONE    = 3'd5,
    PH_SKIP    = 3'd6
  } phase_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_DOLLAR = 3'd1,
    ERR_NO_STAR   = 3'd2,
    ERR_EMPTY     = 3'd3,
    ERR_TOO_LONG  = 3'd4,
    ERR_BAD_HEX   = 3'd5,
    ERR_MISMATCH  = 3'd6
  } err_t;

  // Hex digit of either case: bit 4 set when valid, low nibble the value
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### sv/xcv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcv_front: input acceptance and byte classification
// Takes an item when the queue has room and tags its byte class.
// ----------------------------------------------------------------------------
module xcv_front import xcv_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output cls_t     q_data
);

  logic [4:0] hex;

  // Handshake: accept whenever the queue can take the item
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the byte
  always_comb begin
    hex                = hex_decode(in_item.byte_value);
    q_data.byte_value  = in_item.byte_value;
    q_data.last        = in_item.end_of_line;
    q_data.is_dollar   = (in_item.byte_value == CH_DOLLAR);
    q_data.is_star     = (in_item.byte_value == CH_STAR);
    q_data.is_eol      = (in_item.byte_value == CH_CR) || (in_item.byte_value == CH_LF);
    q_data.hex_ok      = hex[4];
    q_data.hex_digit   = hex[3:0];
  end

endmodule

### sv/xcv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcv_queue: two-entry queue of classified bytes
// Decouples the classifier from the parser; push and pop can happen in the same cycle.
// ----------------------------------------------------------------------------
module xcv_queue import xcv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output cls_t pop_data
);

  cls_t            entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Pointer and fill updates
  always_comb begin
    wr_ptr_nxt = push ? ((wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ((rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/xcv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcv_back: sentence parser and result register
// Runs the framing state machine on each byte and issues a result per line.
// ----------------------------------------------------------------------------
module xcv_back import xcv_pkg::*; #(
  parameter int MAX_BUFFER_SIZE = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] cfg_size,
  input  logic             q_valid,
  input  cls_t             q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  localparam int LW = $clog2(MAX_BUFFER_SIZE + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_BUFFER_SIZE);

  phase_t            phase_r, phase_nxt;
  err_t              err_r, err_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [BYTE_W-1:0] hex_r, hex_nxt;
  logic [31:0]       limit;
  err_t              res_err;
  out_item_t         out_r;
  logic              out_valid_r;

  // Effective length limit
  assign limit = (32'(cfg_size) > 32'(MAX_BUFFER_SIZE)) ? 32'(MAX_BUFFER_SIZE)
                                                         : 32'(cfg_size);

  // A non-final byte never needs the result register
  assign q_pop = q_valid && (!q_data.last || !out_valid_r || out_ready);

  // Next phase and first error
  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    unique case (phase_r)
      PH_START: begin
        if (q_data.is_dollar) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_SKIP;
          err_nxt   = ERR_NO_DOLLAR;
        end
      end
      PH_PAYLOAD: begin
        if (q_data.is_star) begin
          if (len_r == '0) begin
            phase_nxt = PH_SKIP;
            err_nxt   = ERR_EMPTY;
          end else if (32'(len_r) >= limit) begin
            phase_nxt = PH_SKIP;
            err_nxt   = ERR_TOO_LONG;
          end else begin
            phase_nxt = PH_HEX_HI;
          end
        end
      end
      PH_HEX_HI: begin
        if (q_data.hex_ok) begin
          phase_nxt = PH_HEX_LO;
        end else begin
          phase_nxt = PH_SKIP;
          err_nxt   = ERR_BAD_HEX;
        end
      end
      PH_HEX_LO: begin
        if (q_data.hex_ok) begin
          phase_nxt = PH_TAIL;
        end else begin
          phase_nxt = PH_SKIP;
          err_nxt   = ERR_BAD_HEX;
        end
      end
      PH_TAIL: begin
        if (q_data.is_eol) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_SKIP;
          err_nxt   = ERR_BAD_HEX;
        end
      end
      PH_DONE, PH_SKIP: begin
        phase_nxt = phase_r;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Checksum, length and hex accumulation
  always_comb begin
    xor_nxt = xor_r;
    len_nxt = len_r;
    hex_nxt = hex_r;
    if (phase_r == PH_PAYLOAD && !q_data.is_star) begin
      xor_nxt = xor_r ^ q_data.byte_value;
      if (len_r < LEN_MAX) begin
        len_nxt = len_r + 1'b1;
      end
    end
    if (phase_r == PH_HEX_HI && q_data.hex_ok) begin
      hex_nxt = {q_data.hex_digit, 4'h0};
    end
    if (phase_r == PH_HEX_LO && q_data.hex_ok) begin
      hex_nxt = hex_r | {4'h0, q_data.hex_digit};
    end
  end

  // Line verdict
  always_comb begin
    priority if (err_nxt != ERR_NONE) begin
      res_err = err_nxt;
    end else if (phase_nxt == PH_PAYLOAD) begin
      res_err = ERR_NO_STAR;
    end else if (phase_nxt == PH_TAIL || phase_nxt == PH_DONE) begin
      res_err = (hex_nxt == xor_nxt) ? ERR_NONE : ERR_MISMATCH;
    end else begin
      res_err = ERR_BAD_HEX;
    end
  end

  // Line state: cleared after the last byte of a line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      err_r   <= ERR_NONE;
      xor_r   <= '0;
      len_r   <= '0;
      hex_r   <= '0;
    end else if (q_pop) begin
      if (q_data.last) begin
        phase_r <= PH_START;
        err_r   <= ERR_NONE;
        xor_r   <= '0;
        len_r   <= '0;
        hex_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
        xor_r   <= xor_nxt;
        len_r   <= len_nxt;
        hex_r   <= hex_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && q_data.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      out_r.line_ok           <= (res_err == ERR_NONE);
      out_r.error_kind        <= res_err;
      out_r.computed_checksum <= xor_nxt;
      out_r.received_checksum <= (res_err == ERR_NONE || res_err == ERR_MISMATCH)
                                 ? hex_nxt : '0;
      out_r.payload_length    <= LEN_W'(len_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  a_ok_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.line_ok == (out_r.error_kind == ERR_NONE)))
    else $error("line_ok disagrees with error_kind");

  a_recv_only_when_parsed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.received_checksum != '0) |->
      (out_r.error_kind == ERR_NONE || out_r.error_kind == ERR_MISMATCH))
    else $error("received checksum reported for a line without hex digits");

  a_skip_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (err_r != ERR_NONE))
    else $error("skipping a line without a latched error");

  a_start_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |-> (xor_r == '0 && len_r == '0 && err_r == ERR_NONE))
    else $error("line state not cleared at line start");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("result changed while stalled");

endmodule

### sv/xor_checksum_line_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checksum_line_validator: "$payload*HH" line checker
// Checks framing and the XOR checksum of a line fed one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item): one line byte per item, with
//   end_of_line set on the last byte. One result item per line comes out on
//   (out_valid/out_ready/out_item) after its last byte; other bytes give none.
//   cfg_we/cfg_wdata writes the payload buffer size (reset 128); write it only
//   while no line is in flight.
// Throughput: one byte per cycle unless a result waits on out_ready; the
//   parser pops one byte per cycle from the two-entry queue of the classifier.
// Result path: a line's last byte is written into the queue, then popped by
//   the parser as the result register loads; a held result delays the pop.
// Stall: while out_ready is low the result holds; non-final bytes keep
//   flowing, and the next line's last byte waits in the queue, so in_ready
//   drops only when the queue fills.
// Reset: rst_n (synchronous) empties the queue and result register, sets the
//   parser to expect '$' and restores the buffer size to 128.
// ----------------------------------------------------------------------------
module xor_checksum_line_validator import xcv_pkg::*; #(
  parameter int MAX_BUFFER_SIZE = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  logic [LEN_W-1:0] buf_size_r;
  logic             q_full;
  logic             q_push;
  cls_t             q_in;
  logic             q_pop;
  logic             q_valid;
  cls_t             q_out;

  // Payload buffer size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= BUF_SIZE_RESET;
    end else if (cfg_we) begin
      buf_size_r <= cfg_wdata;
    end
  end

  xcv_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  xcv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  xcv_back #(
    .MAX_BUFFER_SIZE (MAX_BUFFER_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_size  (buf_size_r),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for xor_checksum_line_validator
// Feeds "$payload*HH" lines one byte per item under random sender gaps and
// receiver stalls, predicts each line result in the bench and compares every
// result item field by field, across several buffer size settings.
// ----------------------------------------------------------------------------
module testbench;
  import xcv_pkg::*;

  localparam int MAX_BUF = 1024;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;

  xor_checksum_line_validator #(
    .MAX_BUFFER_SIZE(MAX_BUF)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be sent, line results waiting to come out
  in_item_t  pend_bytes[$];
  out_item_t expected_lines[$];
  logic [7:0] line_bytes[$];

  int fail_count  = 0;
  int random_sent = 0;
  bit hold_req    = 1'b0;

  // Line parser mirror and its copy of the buffer size register
  logic [LEN_W-1:0] buf_size;
  phase_t           ln_phase;
  logic [7:0]       ln_xor;
  logic [LEN_W-1:0] ln_len;
  logic [7:0]       ln_hex;
  err_t             ln_err;

  function automatic void clear_line();
    ln_phase = PH_START;
    ln_xor   = '0;
    ln_len   = '0;
    ln_hex   = '0;
    ln_err   = ERR_NONE;
  endfunction

  function automatic void set_error(input err_t code);
    ln_err   = code;
    ln_phase = PH_SKIP;
  endfunction

  // Bit 4 flags a hex digit of either case, low nibble is its value
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    return 5'd0;
  endfunction

  // Advance the parser by one byte; returns 1 with the line result on the last byte
  function automatic bit line_step(input in_item_t it, output out_item_t res);
    logic [LEN_W-1:0] lim;
    logic [4:0]       dv;
    err_t             err;
    lim = (buf_size > MAX_BUF) ? LEN_W'(MAX_BUF) : buf_size;
    dv  = digit_value(it.byte_value);
    res = '0;
    case (ln_phase)
      PH_START: begin
        if (it.byte_value == CH_DOLLAR) ln_phase = PH_PAYLOAD;
        else set_error(ERR_NO_DOLLAR);
      end
      PH_PAYLOAD: begin
        if (it.byte_value == CH_STAR) begin
          if (ln_len == 0) set_error(ERR_EMPTY);
          else if (ln_len >= lim) set_error(ERR_TOO_LONG);
          else ln_phase = PH_HEX_HI;
        end else begin
          ln_xor = ln_xor ^ it.byte_value;
          if (ln_len < MAX_BUF) ln_len = ln_len + 1'b1;
        end
      end
      PH_HEX_HI: begin
        if (dv[4]) begin
          ln_hex   = {dv[3:0], 4'h0};
          ln_phase = PH_HEX_LO;
        end else set_error(ERR_BAD_HEX);
      end
      PH_HEX_LO: begin
        if (dv[4]) begin
          ln_hex[3:0] = dv[3:0];
          ln_phase    = PH_TAIL;
        end else set_error(ERR_BAD_HEX);
      end
      PH_TAIL: begin
        if (it.byte_value == CH_CR || it.byte_value == CH_LF) ln_phase = PH_DONE;
        else set_error(ERR_BAD_HEX);
      end
      default: ;
    endcase

    if (!it.end_of_line) return 1'b0;

    // First latched error wins, otherwise judge by where the line stopped
    if (ln_err != ERR_NONE) err = ln_err;
    else if (ln_phase == PH_PAYLOAD) err = ERR_NO_STAR;
    else if (ln_phase == PH_TAIL || ln_phase == PH_DONE)
      err = (ln_hex == ln_xor) ? ERR_NONE : ERR_MISMATCH;
    else err = ERR_BAD_HEX;

    res.line_ok           = (err == ERR_NONE);
    res.error_kind        = err;
    res.computed_checksum = ln_xor;
    res.received_checksum = (err == ERR_NONE || err == ERR_MISMATCH) ? ln_hex : 8'h00;
    res.payload_length    = ln_len;
    clear_line();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- driver
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pend_bytes.size() > 0) begin
        in_item  <= pend_bytes.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // new burst; a quarter of them run back to back with no gap
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int rx_mode   = 0;
  int mode_left = 0;
  int hold_left = 0;

  task automatic report_fail(input out_item_t want, input out_item_t got, input bit orphan);
    if (fail_count < 10) begin
      if (orphan)
        $display("%0t: result with none expected: ok=%0d err=%0d calc=%02h recv=%02h len=%0d",
                 $realtime, got.line_ok, got.error_kind, got.computed_checksum,
                 got.received_checksum, got.payload_length);
      else
        $display({"%0t: expected ok=%0d err=%0d calc=%02h recv=%02h len=%0d,",
                  " got ok=%0d err=%0d calc=%02h recv=%02h len=%0d"},
                 $realtime, want.line_ok, want.error_kind, want.computed_checksum,
                 want.received_checksum, want.payload_length, got.line_ok, got.error_kind,
                 got.computed_checksum, got.received_checksum, got.payload_length);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : mon
    out_item_t want;
    out_item_t pred;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      // check the result item taken at this edge
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          report_fail('0, out_item, 1'b1);
        end else begin
          want = expected_lines.pop_front();
          if (out_item.line_ok !== want.line_ok ||
              out_item.error_kind !== want.error_kind ||
              out_item.computed_checksum !== want.computed_checksum ||
              out_item.received_checksum !== want.received_checksum ||
              out_item.payload_length !== want.payload_length)
            report_fail(want, out_item, 1'b0);
        end
      end

      // predict from the byte accepted at this edge
      if (in_valid && in_ready) begin
        if (line_step(in_item, pred)) expected_lines.push_back(pred);
      end

      // receiver: long hold when asked, otherwise a changing stall pattern
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + (n - 4'd10);
  endfunction

  task automatic send_line();
    int i;
    for (i = 0; i < line_bytes.size(); i++)
      pend_bytes.push_back(in_item_t'{byte_value: line_bytes[i],
                                      end_of_line: (i == line_bytes.size() - 1)});
  endtask

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    line_bytes = {};
    add_str(s);
    send_line();
  endtask

  // Random payload bytes, never a star; returns their XOR
  function automatic logic [7:0] add_payload(input int plen);
    logic [7:0] b;
    logic [7:0] sum;
    sum = '0;
    repeat (plen) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_STAR) b = 8'h2B;
      sum = sum ^ b;
      line_bytes.push_back(b);
    end
    return sum;
  endfunction

  task automatic add_checksum(input logic [7:0] ck);
    line_bytes.push_back(CH_STAR);
    line_bytes.push_back(hex_char(ck[7:4], 1'($urandom_range(0, 1))));
    line_bytes.push_back(hex_char(ck[3:0], 1'($urandom_range(0, 1))));
  endtask

  task automatic send_long_line(input int plen, input bit with_star);
    logic [7:0] sum;
    line_bytes = {};
    line_bytes.push_back(CH_DOLLAR);
    sum = add_payload(plen);
    if (with_star) add_checksum(sum);
    send_line();
  endtask

  // Mostly well-formed lines, some broken ones and some plain noise
  task automatic add_random_line();
    int         r;
    int         plen;
    int         near_len;
    int         lim;
    logic [7:0] sum;
    logic [7:0] ck;
    line_bytes = {};
    lim = (buf_size > MAX_BUF) ? MAX_BUF : buf_size;
    r   = $urandom_range(0, 99);
    if (r >= 90) begin
      repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_bytes.push_back(CH_DOLLAR);
      near_len = (lim > 40) ? 40 : lim;
      case ($urandom_range(0, 9))
        0:       plen = 0;
        1, 2:    plen = $urandom_range((near_len > 2) ? near_len - 2 : 0, near_len + 1);
        default: plen = $urandom_range(1, 10);
      endcase
      sum = add_payload(plen);
      ck  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : sum;
      add_checksum(ck);
      case ($urandom_range(0, 3))
        1: line_bytes.push_back(CH_CR);
        2: line_bytes.push_back(CH_LF);
        3: begin
          line_bytes.push_back(CH_LF);
          line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      // broken lines: cut short or one byte replaced
      if (r >= 75) begin
        if ($urandom_range(0, 1)) begin
          plen = $urandom_range(1, line_bytes.size() - 1);
          while (line_bytes.size() > plen) void'(line_bytes.pop_back());
        end else begin
          line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end
    end
    send_line();
    random_sent += line_bytes.size();
  endtask

  task automatic run_random(input int n);
    int start;
    start = random_sent;
    while (random_sent - start < n) add_random_line();
  endtask

  // Sender pauses here until every result is in and the pipeline is empty;
  // sampled mid-cycle so the clocked processes have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pend_bytes.size() != 0 || in_valid || expected_lines.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_buf_size(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    buf_size  = v;
  endtask

  initial begin
    clear_line();
    buf_size = BUF_SIZE_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines at the reset buffer size
    line_bytes = {};
    add_str("$j*6a");
    line_bytes.push_back(CH_CR);
    send_line();
    line_bytes = {};
    add_str("$J*4A");
    line_bytes.push_back(CH_LF);
    add_str("Z");
    send_line();
    send_text("X");
    send_text("$A");
    send_text("$");
    send_text("$*");
    send_text("$j*");
    send_text("$j*6");
    send_text("$j*6g");
    send_text("$j*6aX");
    send_text("$j*00");
    line_bytes = {};
    line_bytes.push_back(CH_DOLLAR);
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    add_str("*FF");
    send_line();
    wait_idle();

    // random lines with one long receiver hold while bytes keep coming
    run_random(160);
    hold_req = 1'b1;
    wait_idle();

    // largest buffer: longer payloads pass, a line without a star fails
    write_buf_size(11'd1024);
    send_long_line(40, 1'b1);
    send_long_line(41, 1'b0);
    run_random(50);
    wait_idle();

    // tiny buffers reject every nonempty payload
    write_buf_size(11'd1);
    send_text("$j*6a");
    run_random(40);
    wait_idle();

    write_buf_size(11'd0);
    send_text("$j*6a");
    run_random(40);
    wait_idle();

    // above the maximum: clamped to the largest buffer
    write_buf_size(11'd2047);
    run_random(50);
    wait_idle();

    write_buf_size(11'd5);
    run_random(80);
    wait_idle();

    repeat (2) begin
      write_buf_size(11'($urandom_range(2, 30)));
      run_random(70);
      wait_idle();
    end

    if (fail_count == 0 && expected_lines.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
